[sv/arhc_pkg.sv]
// shared types and codes for the address range hit counter
// no dependencies; used by arhc_ctrl, the top level and the testbench
`default_nettype none

package arhc_pkg;

    localparam int MAX_REGIONS_DEF = 64;

    // command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CHECK = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_IGNORED  = 3'd3;
    localparam logic [2:0] ST_BADINDEX = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] owner_pid;
        logic [31:0] region_base;
        logic [31:0] region_size;
        logic [31:0] probe_address;
        logic [5:0]  entry_select;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  entry_index;
        logic [31:0] hit_count;
    } rsp_t;

endpackage

`default_nettype wire

[sv/arhc_ram.sv]
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
`default_nettype none

module arhc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/arhc_ctrl.sv]
// command sequencer: add, region scan with read-modify-write of hit counts, read
// depends on arhc_pkg; drives the region and hit memories in the top level
`default_nettype none

module arhc_ctrl #(
    parameter int MAX_REGIONS = arhc_pkg::MAX_REGIONS_DEF,
    parameter int IDXW        = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [31:0]    watched_pid,
    input  wire logic           start,
    input  wire arhc_pkg::req_t req,
    output logic                busy,
    output logic                done,
    output arhc_pkg::rsp_t      rsp,
    // memory side
    output logic                region_we,
    output logic                hit_we,
    output logic [IDXW-1:0]     waddr,
    output logic [64:0]         region_wdata,
    output logic [31:0]         hit_wdata,
    output logic                re,
    output logic [IDXW-1:0]     raddr,
    input  wire logic [64:0]    region_rdata,
    input  wire logic [31:0]    hit_rdata
);

    localparam int CNTW = $clog2(MAX_REGIONS + 1);
    localparam int CW   = (CNTW > 6) ? CNTW : 6;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic [CNTW-1:0]     ptr_reg, ptr_next;
    logic [IDXW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [31:0]         addr_reg, addr_next;
    logic [5:0]          sel_reg, sel_next;
    logic                done_reg, done_next;
    arhc_pkg::rsp_t      rsp_reg, rsp_next;

    logic [CW-1:0]       sel_ext;
    logic [CW-1:0]       cnt_ext;
    logic                sel_ok;
    logic [31:0]         cur_start;
    logic [32:0]         cur_end;
    logic                hit;
    logic [31:0]         hit_inc;
    logic [IDXW-1:0]     idx_src;
    logic [IDXW+5:0]     idx_wide;
    logic [5:0]          idx_out;

    assign sel_ext   = CW'(req.entry_select);
    assign cnt_ext   = CW'(cnt_reg);
    assign sel_ok    = sel_ext < cnt_ext;
    assign cur_start = region_rdata[64:33];
    assign cur_end   = region_rdata[32:0];
    assign hit       = (addr_reg >= cur_start) && ({1'b0, addr_reg} < cur_end);
    assign hit_inc   = (hit_rdata == 32'hFFFF_FFFF) ? hit_rdata : hit_rdata + 32'd1;

    // low six bits of a table index
    assign idx_src  = (state_reg == S_SCAN) ? cmp_idx_reg : cnt_reg[IDXW-1:0];
    assign idx_wide = (IDXW + 6)'(idx_src);
    assign idx_out  = idx_wide[5:0];

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ptr_next     = ptr_reg;
        cmp_idx_next = cmp_idx_reg;
        addr_next    = addr_reg;
        sel_next     = sel_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        region_we    = 1'b0;
        hit_we       = 1'b0;
        waddr        = cnt_reg[IDXW-1:0];
        region_wdata = {req.region_base, {1'b0, req.region_base} + {1'b0, req.region_size}};
        hit_wdata    = 32'd0;
        re           = 1'b0;
        raddr        = ptr_reg[IDXW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (req.cmd)
                        arhc_pkg::CMD_ADD:
                        begin
                            done_next = 1'b1;
                            if (req.owner_pid == 32'd0 || req.owner_pid != watched_pid)
                            begin
                                rsp_next = '{arhc_pkg::ST_IGNORED, 6'd0, 32'd0};
                            end
                            else if (cnt_reg == CNTW'(MAX_REGIONS))
                            begin
                                rsp_next = '{arhc_pkg::ST_FULL, 6'd0, 32'd0};
                            end
                            else
                            begin
                                region_we = 1'b1;
                                hit_we    = 1'b1;
                                cnt_next  = cnt_reg + 1'b1;
                                rsp_next  = '{arhc_pkg::ST_OK, idx_out, 32'd0};
                            end
                        end
                        arhc_pkg::CMD_CHECK:
                        begin
                            addr_next = req.probe_address;
                            if (cnt_reg == '0)
                            begin
                                done_next = 1'b1;
                                rsp_next  = '{arhc_pkg::ST_MISS, 6'd0, 32'd0};
                            end
                            else
                            begin
                                re           = 1'b1;
                                raddr        = '0;
                                cmp_idx_next = '0;
                                ptr_next     = CNTW'(1);
                                state_next   = S_SCAN;
                            end
                        end
                        arhc_pkg::CMD_READ:
                        begin
                            sel_next = req.entry_select;
                            if (sel_ok)
                            begin
                                re         = 1'b1;
                                raddr      = sel_ext[IDXW-1:0];
                                state_next = S_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                                rsp_next  = '{arhc_pkg::ST_BADINDEX, req.entry_select, 32'd0};
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            rsp_next  = '{arhc_pkg::ST_IGNORED, 6'd0, 32'd0};
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    hit_we     = 1'b1;
                    waddr      = cmp_idx_reg;
                    hit_wdata  = hit_inc;
                    done_next  = 1'b1;
                    rsp_next   = '{arhc_pkg::ST_OK, idx_out, hit_inc};
                    state_next = S_IDLE;
                end
                else if (ptr_reg == cnt_reg)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{arhc_pkg::ST_MISS, 6'd0, 32'd0};
                    state_next = S_IDLE;
                end
                else
                begin
                    re           = 1'b1;
                    cmp_idx_next = ptr_reg[IDXW-1:0];
                    ptr_next     = ptr_reg + 1'b1;
                end
            end
            S_READ:
            begin
                done_next  = 1'b1;
                rsp_next   = '{arhc_pkg::ST_OK, sel_reg, hit_rdata};
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        cmp_idx_reg <= cmp_idx_next;
        addr_reg    <= addr_next;
        sel_reg     <= sel_next;
        rsp_reg     <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(MAX_REGIONS))
        else $error("region count beyond table size");

    a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CNTW'(cmp_idx_reg) < cnt_reg && ptr_reg <= cnt_reg))
        else $error("scan walked past stored regions");

    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_IDLE && done_reg))
        else $error("read entry did not complete");

    a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> (done_reg && rsp_reg.status == arhc_pkg::ST_OK))
        else $error("region count changed without a successful add");
`endif

endmodule

`default_nettype wire

[sv/address_range_hit_counter.sv]
// address range hit counter: a start/busy command interface over a
// table of address regions, each with a hit counter; a check command walks
// the stored regions one per cycle out of a region memory, increments the
// first match in a hit memory (saturating) and reports one result item.
// add, unused and rejected commands finish without raising busy; a read entry
// item holds busy in S_READ; a check item holds busy while it walks the
// stored regions over the single region read port (one region compared per
// cycle). every item yields exactly one result item, shown for one cycle
// with done high, in the cycle after the last work cycle; the receiver
// cannot stall, so results must be taken when shown. the user must write
// watched_pid via cfg_we/cfg_wdata only while idle; unenforced by the block.
// depends on arhc_pkg, arhc_ctrl, arhc_ram
`default_nettype none

module address_range_hit_counter #(
    parameter int MAX_REGIONS = arhc_pkg::MAX_REGIONS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // configuration
    input  wire logic           cfg_we,
    input  wire logic [31:0]    cfg_wdata,
    // command item
    input  wire logic           start,
    input  wire arhc_pkg::req_t req,
    output logic                busy,
    // result item
    output logic                done,
    output arhc_pkg::rsp_t      rsp
);

    localparam int IDXW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    // watched process id, zero never matches
    logic [31:0] watched_pid_reg;

    logic            region_we;
    logic            hit_we;
    logic [IDXW-1:0] waddr;
    logic [64:0]     region_wdata;
    logic [31:0]     hit_wdata;
    logic            re;
    logic [IDXW-1:0] raddr;
    logic [64:0]     region_rdata;
    logic [31:0]     hit_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watched_pid_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            watched_pid_reg <= cfg_wdata;
        end
    end

    // sequencer: add, scan with read-modify-write, read entry
    arhc_ctrl #(
        .MAX_REGIONS (MAX_REGIONS),
        .IDXW        (IDXW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .watched_pid  (watched_pid_reg),
        .start        (start),
        .req          (req),
        .busy         (busy),
        .done         (done),
        .rsp          (rsp),
        .region_we    (region_we),
        .hit_we       (hit_we),
        .waddr        (waddr),
        .region_wdata (region_wdata),
        .hit_wdata    (hit_wdata),
        .re           (re),
        .raddr        (raddr),
        .region_rdata (region_rdata),
        .hit_rdata    (hit_rdata)
    );

    // region memory: start address over exclusive 33-bit end address
    arhc_ram #(
        .WIDTH (65),
        .DEPTH (MAX_REGIONS),
        .AW    (IDXW)
    ) u_region_ram (
        .clk   (clk),
        .we    (region_we),
        .waddr (waddr),
        .wdata (region_wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (region_rdata)
    );

    // hit counter memory, shares the read address with the region memory
    arhc_ram #(
        .WIDTH (32),
        .DEPTH (MAX_REGIONS),
        .AW    (IDXW)
    ) u_hit_ram (
        .clk   (clk),
        .we    (hit_we),
        .waddr (waddr),
        .wdata (hit_wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (hit_rdata)
    );

endmodule

`default_nettype wire

[test/arhc_hit_monitor.sv]
// checker for the address range hit counter: watches the command, result and
// configuration ports, predicts each result item and compares it field by field
// depends on arhc_pkg
`default_nettype none

module arhc_hit_monitor #(
    parameter int NREG = arhc_pkg::MAX_REGIONS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [31:0]    cfg_wdata,
    input  wire logic           start,
    input  wire logic           busy,
    input  wire arhc_pkg::req_t req,
    input  wire logic           done,
    input  wire arhc_pkg::rsp_t rsp,
    output int                  mismatch_count,
    output int                  results_owed
);

    // shadow of the block's state
    logic [31:0] watch_pid;
    logic [31:0] region_lo [NREG];
    logic [32:0] region_hi [NREG];
    logic [31:0] region_hits [NREG];
    int          regions_held;

    arhc_pkg::rsp_t pending_results [$];

    // applies one command to the shadow table and returns its result item
    function automatic arhc_pkg::rsp_t region_table_step(input arhc_pkg::req_t item);
        arhc_pkg::rsp_t res;
        logic           found;
        res = '0;
        res.status = arhc_pkg::ST_IGNORED;
        found = 1'b0;
        case (item.cmd)
            arhc_pkg::CMD_ADD:
            begin
                if (item.owner_pid == '0 || item.owner_pid != watch_pid)
                    res.status = arhc_pkg::ST_IGNORED;
                else if (regions_held >= NREG)
                    res.status = arhc_pkg::ST_FULL;
                else
                begin
                    region_lo[regions_held]   = item.region_base;
                    region_hi[regions_held]   = {1'b0, item.region_base} + {1'b0, item.region_size};
                    region_hits[regions_held] = '0;
                    res.status      = arhc_pkg::ST_OK;
                    res.entry_index = 6'(regions_held);
                    regions_held++;
                end
            end
            arhc_pkg::CMD_CHECK:
            begin
                res.status = arhc_pkg::ST_MISS;
                for (int i = 0; i < regions_held; i++)
                begin
                    if (!found && item.probe_address >= region_lo[i]
                        && {1'b0, item.probe_address} < region_hi[i])
                    begin
                        found = 1'b1;
                        if (region_hits[i] != 32'hFFFF_FFFF)
                            region_hits[i] = region_hits[i] + 32'd1;
                        res.status      = arhc_pkg::ST_OK;
                        res.entry_index = 6'(i);
                        res.hit_count   = region_hits[i];
                    end
                end
            end
            arhc_pkg::CMD_READ:
            begin
                res.entry_index = item.entry_select;
                if (int'(item.entry_select) < regions_held)
                begin
                    res.status    = arhc_pkg::ST_OK;
                    res.hit_count = region_hits[item.entry_select];
                end
                else
                    res.status = arhc_pkg::ST_BADINDEX;
            end
            default:
                res.status = arhc_pkg::ST_IGNORED;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        arhc_pkg::rsp_t want;
        if (!rst_n)
        begin
            watch_pid      = '0;
            regions_held   = 0;
            pending_results.delete();
            results_owed   = 0;
            mismatch_count = 0;
        end
        else
        begin
            // results first, so an item taken at this edge never meets its own slot
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result item with nothing expected: status %0d index %0d count %0d",
                           rsp.status, rsp.entry_index, rsp.hit_count);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        mismatch_count++;
                    end
                    if (rsp.entry_index !== want.entry_index)
                    begin
                        $error("entry_index: expected %0d, got %0d",
                               want.entry_index, rsp.entry_index);
                        mismatch_count++;
                    end
                    if (rsp.hit_count !== want.hit_count)
                    begin
                        $error("hit_count: expected %0d, got %0d",
                               want.hit_count, rsp.hit_count);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_we)
                watch_pid = cfg_wdata;
            if (start && !busy)
                pending_results.push_back(region_table_step(req));
            results_owed = pending_results.size();
        end
    end

endmodule

`default_nettype wire

[test/tb.sv]
// top of the address range hit counter testbench: clock, reset, command
// stimulus, watched_pid writes and the final verdict
// depends on arhc_pkg, address_range_hit_counter and arhc_hit_monitor
`default_nettype none

module tb;

    localparam int NREG = arhc_pkg::MAX_REGIONS_DEF;

    // the package names no code for the fourth command value
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // every input starts at a known value
    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cfg_we    = 1'b0;
    logic [31:0]    cfg_wdata = '0;
    logic           start     = 1'b0;
    arhc_pkg::req_t req       = '0;
    logic           busy;
    logic           done;
    arhc_pkg::rsp_t rsp;

    int mismatch_count;
    int results_owed;

    // stimulus side bookkeeping: current watched id, burst pacing, and the
    // regions we have tried to add so checks can be aimed at them
    logic [31:0] cur_pid = '0;
    int          burst_left = 0;
    logic        steady = 1'b0;
    logic [31:0] aim_base [$];
    logic [31:0] aim_size [$];

    address_range_hit_counter #(
        .MAX_REGIONS (NREG)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp)
    );

    arhc_hit_monitor #(
        .NREG (NREG)
    ) monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .start          (start),
        .busy           (busy),
        .req            (req),
        .done           (done),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // 20 unit clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // hard stop, several times the slowest correct run
    // (every item a full 64 entry walk plus the longest sender gap)
    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic arhc_pkg::req_t mk(input logic [1:0] cmd, input logic [31:0] pid,
                                          input logic [31:0] base, input logic [31:0] size,
                                          input logic [31:0] addr, input logic [5:0] sel);
        arhc_pkg::req_t item;
        item.cmd           = cmd;
        item.owner_pid     = pid;
        item.region_base   = base;
        item.region_size   = size;
        item.probe_address = addr;
        item.entry_select  = sel;
        return item;
    endfunction

    // one random command; unused fields always carry random noise so every
    // input bit toggles
    function automatic arhc_pkg::req_t random_item(input int add_pct);
        arhc_pkg::req_t item;
        int unsigned    roll;
        int unsigned    k;
        logic [31:0]    b;
        logic [31:0]    s;
        item = mk(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom,
                  6'($urandom_range(0, 63)));
        roll = $urandom_range(0, 99);
        if (roll < add_pct)
        begin
            item.cmd = arhc_pkg::CMD_ADD;
            // mostly well-formed adds for the watched id, some zero or foreign ids
            if ($urandom_range(0, 99) < 75)
                item.owner_pid = cur_pid;
            else if ($urandom_range(0, 3) == 0)
                item.owner_pid = '0;
            // bases clustered low or high so regions overlap and first match matters
            case ($urandom_range(0, 3))
                0: b = 32'h0000_1000 * $urandom_range(0, 15) + $urandom_range(0, 255);
                1: b = 32'hFFFF_F000 + $urandom_range(0, 4095);
                2: b = $urandom & 32'hFFFF_0000;
                default: b = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0: s = '0;                              // empty region
                1: s = $urandom_range(1, 64);
                2: s = $urandom_range(1, 32'h2000);
                3: s = 32'hFFFF_FFFF;                   // end past the 32 bit space
                default: s = $urandom_range(1, 32'h0010_0000);
            endcase
            item.region_base = b;
            item.region_size = s;
            if (item.owner_pid == cur_pid && cur_pid != '0)
            begin
                aim_base.push_back(b);
                aim_size.push_back(s);
            end
        end
        else if (roll < 80)
        begin
            item.cmd = arhc_pkg::CMD_CHECK;
            if (aim_base.size() != 0 && $urandom_range(0, 4) != 0)
            begin
                k = $urandom_range(0, aim_base.size() - 1);
                b = aim_base[k];
                s = aim_size[k];
                // land on and just around the region bounds
                case ($urandom_range(0, 4))
                    0: item.probe_address = b;
                    1: item.probe_address = b - 32'd1;
                    2: item.probe_address = b + s - 32'd1;
                    3: item.probe_address = b + s;
                    default: item.probe_address = (s == '0) ? b : b + ($urandom % s);
                endcase
            end
            else if ($urandom_range(0, 1) == 0)
                item.probe_address = 32'h0000_1000 * $urandom_range(0, 15)
                                     + $urandom_range(0, 8191);
        end
        else if (roll < 95)
            item.cmd = arhc_pkg::CMD_READ;
        return item;
    endfunction

    // hands one item over: start stays high across back to back items, and a
    // new burst may open with a gap of random length
    task automatic issue(input arhc_pkg::req_t item);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (!steady && $urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        req   <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // drop start and wait until every result item has come back;
    // the count is read on the falling edge to stay clear of the monitor
    task automatic settle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (results_owed != 0);
        @(posedge clk);
    endtask

    // watched_pid may only change while the block is idle
    task automatic set_watch(input logic [31:0] pid);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= pid;
        cur_pid    = pid;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(input logic [31:0] pid, input int add_pct,
                                input logic no_gaps, input int count);
        set_watch(pid);
        steady = no_gaps;
        repeat (count)
            issue(random_item(add_pct));
    endtask

    initial
    begin
        logic [31:0] pid;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table with watched_pid at its reset value of zero:
        // adds are ignored (zero id never matches), checks miss, reads are out of range
        issue(mk(arhc_pkg::CMD_ADD, 32'h0, 32'h100, 32'h10, 32'h0, 6'd0));
        issue(mk(arhc_pkg::CMD_ADD, 32'h1234_5678, 32'h100, 32'h10, 32'h0, 6'd0));
        issue(mk(arhc_pkg::CMD_CHECK, 32'h0, 32'h0, 32'h0, 32'h0, 6'd0));
        issue(mk(arhc_pkg::CMD_READ, 32'h0, 32'h0, 32'h0, 32'h0, 6'd0));
        issue(mk(arhc_pkg::CMD_READ, 32'h0, 32'h0, 32'h0, 32'h0, 6'd63));
        issue(mk(CMD_UNUSED, '1, '1, '1, '1, 6'd63));

        // all-ones watched id; a region whose end runs past 2^32, an empty one,
        // and an ordinary one behind the empty one
        set_watch(32'hFFFF_FFFF);
        issue(mk(arhc_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h0, 6'd0));
        issue(mk(arhc_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 6'd0));
        issue(mk(arhc_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h0, 32'h10, 32'h0, 6'd0));
        issue(mk(arhc_pkg::CMD_ADD, 32'hFFFF_FFFE, 32'h0, 32'h10, 32'h0, 6'd0));
        issue(mk(arhc_pkg::CMD_CHECK, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 6'd0));
        // address 0 must skip the empty region and hit the third entry
        issue(mk(arhc_pkg::CMD_CHECK, 32'h0, 32'h0, 32'h0, 32'h0, 6'd0));
        issue(mk(arhc_pkg::CMD_CHECK, 32'h0, 32'h0, 32'h0, 32'hF, 6'd0));
        // exclusive end and one below the start both miss
        issue(mk(arhc_pkg::CMD_CHECK, 32'h0, 32'h0, 32'h0, 32'h10, 6'd0));
        issue(mk(arhc_pkg::CMD_CHECK, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFF0, 6'd0));
        issue(mk(arhc_pkg::CMD_CHECK, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFEF, 6'd0));
        issue(mk(arhc_pkg::CMD_READ, 32'h0, 32'h0, 32'h0, 32'h0, 6'd0));
        issue(mk(arhc_pkg::CMD_READ, 32'h0, 32'h0, 32'h0, 32'h0, 6'd1));
        issue(mk(arhc_pkg::CMD_READ, 32'h0, 32'h0, 32'h0, 32'h0, 6'd2));
        issue(mk(arhc_pkg::CMD_READ, 32'h0, 32'h0, 32'h0, 32'h0, 6'd3));
        // a saturating counter needs 2^32 hits on one entry, out of reach here

        // random part: the first phase fills the table, so the later ones
        // see full-table adds and checks that walk all 64 entries
        do
            pid = $urandom;
        while (pid == '0);
        random_phase(pid, 35, 1'b0, 460);
        random_phase(32'h0, 10, 1'b1, 460);
        random_phase(32'hFFFF_FFFF, 30, 1'b0, 460);
        do
            pid = $urandom;
        while (pid == '0);
        random_phase(pid, 20, 1'b0, 460);

        // drain, then leave room for a full walk in case something stray follows
        settle();
        repeat (NREG + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
sv/arhc_pkg.sv
sv/arhc_ram.sv
sv/arhc_ctrl.sv
sv/address_range_hit_counter.sv
test/arhc_hit_monitor.sv
test/tb.sv
